### hw/rtl/ume_pkg.sv
// ----------------------------------------------------------------------------
// ume_pkg
// Shared types and constants for the macro instruction expander: action codes,
// the classified request format and the opcode register set.
// ----------------------------------------------------------------------------
package ume_pkg;

    // action codes of an incoming request
    localparam logic [2:0] ACT_COMPLEMENT = 3'd0;
    localparam logic [2:0] ACT_MOVE       = 3'd1;
    localparam logic [2:0] ACT_NEGATE     = 3'd2;
    localparam logic [2:0] ACT_SUBTRACT   = 3'd3;
    localparam logic [2:0] ACT_AND        = 3'd4;
    localparam logic [2:0] ACT_OR         = 3'd5;
    localparam logic [2:0] ACT_LOAD       = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_NAND_OPCODE = 2'd0;
    localparam logic [1:0] CFG_ADD_OPCODE  = 2'd1;
    localparam logic [1:0] CFG_MUL_OPCODE  = 2'd2;
    localparam logic [1:0] CFG_LV_OPCODE   = 2'd3;

    // opcode reset values
    localparam logic [3:0] NAND_OPCODE_RST = 4'd6;
    localparam logic [3:0] ADD_OPCODE_RST  = 4'd3;
    localparam logic [3:0] MUL_OPCODE_RST  = 4'd4;
    localparam logic [3:0] LV_OPCODE_RST   = 4'd13;

    // load-value immediate width
    localparam int unsigned LIT_BITS = 25;

    // expansion kind chosen by the front end
    typedef enum logic [3:0] {
        KIND_COMPLEMENT,
        KIND_MOVE,
        KIND_NEGATE,
        KIND_SUBTRACT,
        KIND_AND,
        KIND_OR,
        KIND_LIT_SHORT,
        KIND_LIT_INV,
        KIND_LIT_WIDE,
        KIND_MISSING_TEMP
    } kind_t;

    // classified request as it travels through the command queue
    typedef struct packed {
        kind_t       kind;
        logic [2:0]  temp_reg;
        logic [2:0]  reg_a;
        logic [2:0]  reg_b;
        logic [2:0]  reg_c;
        logic [31:0] literal;
    } cmd_t;

    // opcode register set
    typedef struct packed {
        logic [3:0] nand_op;
        logic [3:0] add_op;
        logic [3:0] mul_op;
        logic [3:0] lv_op;
    } opc_t;

endpackage

### hw/rtl/ume_front.sv
// ----------------------------------------------------------------------------
// ume_front
// Request classifier: picks the expansion kind for each request, folds the
// missing-temporary check in, and drops undefined actions.
// ----------------------------------------------------------------------------
module ume_front
    import ume_pkg::*;
(
    input  logic        accept,
    input  logic [2:0]  action,
    input  logic        temp_present,
    input  logic [2:0]  temp_reg,
    input  logic [2:0]  reg_a,
    input  logic [2:0]  reg_b,
    input  logic [2:0]  reg_c,
    input  logic [31:0] literal,
    output logic        cmd_push,
    output cmd_t        cmd
);

    logic  known;
    logic  need_temp;
    kind_t kind;
    logic  lit_fits;
    logic  inv_fits;

    // literal range checks
    assign lit_fits = (literal[31:LIT_BITS] == '0);
    assign inv_fits = (literal[31:LIT_BITS] == '1);

    // kind selection
    always_comb
    begin
        known     = 1'b1;
        need_temp = 1'b0;
        kind      = KIND_COMPLEMENT;
        case (action)
            ACT_COMPLEMENT: kind = KIND_COMPLEMENT;
            ACT_MOVE:       kind = KIND_MOVE;
            ACT_NEGATE:
            begin
                kind      = KIND_NEGATE;
                need_temp = 1'b1;
            end
            ACT_SUBTRACT:
            begin
                kind      = KIND_SUBTRACT;
                need_temp = 1'b1;
            end
            ACT_AND:        kind = KIND_AND;
            ACT_OR:
            begin
                kind      = KIND_OR;
                need_temp = 1'b1;
            end
            ACT_LOAD:
            begin
                if (lit_fits)
                begin
                    kind = KIND_LIT_SHORT;
                end
                else if (inv_fits)
                begin
                    kind = KIND_LIT_INV;
                end
                else
                begin
                    kind      = KIND_LIT_WIDE;
                    need_temp = 1'b1;
                end
            end
            default:        known = 1'b0;
        endcase
    end

    // queue entry
    always_comb
    begin
        cmd.kind     = (need_temp && !temp_present) ? KIND_MISSING_TEMP : kind;
        cmd.temp_reg = temp_reg;
        cmd.reg_a    = reg_a;
        cmd.reg_b    = reg_b;
        cmd.reg_c    = reg_c;
        cmd.literal  = literal;
    end

    assign cmd_push = accept && known;

endmodule

### hw/rtl/ume_cmd_fifo.sv
// ----------------------------------------------------------------------------
// ume_cmd_fifo
// Short queue of classified requests between the front end and the sequencer.
// DEPTH must be at least 2.
// ----------------------------------------------------------------------------
module ume_cmd_fifo
    import ume_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    input  cmd_t wr_cmd,
    input  logic rd_taken,
    output cmd_t rd_cmd,
    output logic q_full,
    output logic q_empty
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_wr;
    logic          do_rd;

    assign q_full  = (count_reg == FULL_CNT);
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_valid && !q_full;
    assign do_rd   = rd_taken && !q_empty;
    assign rd_cmd  = entry_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    // occupancy agrees with the pointers
    a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0 && count_reg != FULL_CNT) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("command queue count disagrees with pointers");

endmodule

### hw/rtl/ume_back.sv
// ----------------------------------------------------------------------------
// ume_back
// Expansion sequencer: unless the output is held, walks the head request one
// instruction word per cycle into a registered result stage, then dequeues it.
// ----------------------------------------------------------------------------
module ume_back
    import ume_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  opc_t        opc,
    input  cmd_t        cmd,
    input  logic        cmd_empty,
    output logic        cmd_pop,
    input  logic        pop,
    output logic        empty,
    output logic [31:0] instr_word,
    output logic        last_word,
    output logic        missing_temp
);

    logic [2:0]  step_reg;
    logic [2:0]  step_next;
    logic        valid_reg;
    logic        valid_next;
    logic [31:0] word_reg;
    logic        last_reg;
    logic        err_reg;
    logic        advance;
    logic        take;
    logic [2:0]  len;
    logic        at_last;
    logic [31:0] word;

    // three-register instruction word
    function automatic logic [31:0] word3(input logic [3:0] op, input logic [2:0] a,
                                          input logic [2:0] b, input logic [2:0] c);
        word3 = {op, 19'd0, a, b, c};
    endfunction

    // load-value instruction word
    function automatic logic [31:0] word_lv(input logic [3:0] op, input logic [2:0] r,
                                            input logic [LIT_BITS-1:0] v);
        word_lv = {op, r, v};
    endfunction

    // number of words per kind
    always_comb
    begin
        case (cmd.kind)
            KIND_COMPLEMENT:   len = 3'd1;
            KIND_MOVE:         len = 3'd2;
            KIND_NEGATE:       len = 3'd3;
            KIND_SUBTRACT:     len = 3'd4;
            KIND_AND:          len = 3'd2;
            KIND_OR:           len = 3'd3;
            KIND_LIT_SHORT:    len = 3'd1;
            KIND_LIT_INV:      len = 3'd2;
            KIND_LIT_WIDE:     len = 3'd5;
            KIND_MISSING_TEMP: len = 3'd1;
            default:           len = 3'd1;
        endcase
    end

    // word for the current step
    always_comb
    begin
        logic [2:0] t;
        logic [2:0] a;
        logic [2:0] b;
        logic [2:0] c;
        logic [LIT_BITS-1:0] one;
        t    = cmd.temp_reg;
        a    = cmd.reg_a;
        b    = cmd.reg_b;
        c    = cmd.reg_c;
        one  = LIT_BITS'(1);
        word = '0;
        case (cmd.kind)
            KIND_COMPLEMENT: word = word3(opc.nand_op, a, b, b);
            KIND_MOVE:
                word = (step_reg == 3'd0) ? word3(opc.nand_op, a, b, b)
                                          : word3(opc.nand_op, a, a, a);
            KIND_NEGATE:
            begin
                case (step_reg)
                    3'd0:    word = word3(opc.nand_op, t, b, b);
                    3'd1:    word = word_lv(opc.lv_op, a, one);
                    default: word = word3(opc.add_op, a, a, t);
                endcase
            end
            KIND_SUBTRACT:
            begin
                case (step_reg)
                    3'd0:    word = word3(opc.nand_op, t, c, c);
                    3'd1:    word = word3(opc.add_op, a, b, t);
                    3'd2:    word = word_lv(opc.lv_op, t, one);
                    default: word = word3(opc.add_op, a, a, t);
                endcase
            end
            KIND_AND:
                word = (step_reg == 3'd0) ? word3(opc.nand_op, a, b, c)
                                          : word3(opc.nand_op, a, a, a);
            KIND_OR:
            begin
                case (step_reg)
                    3'd0:    word = word3(opc.nand_op, t, b, b);
                    3'd1:    word = word3(opc.nand_op, a, c, c);
                    default: word = word3(opc.nand_op, a, t, a);
                endcase
            end
            KIND_LIT_SHORT:
                word = word_lv(opc.lv_op, a, cmd.literal[LIT_BITS-1:0]);
            KIND_LIT_INV:
                word = (step_reg == 3'd0) ? word_lv(opc.lv_op, a, ~cmd.literal[LIT_BITS-1:0])
                                          : word3(opc.nand_op, a, a, a);
            KIND_LIT_WIDE:
            begin
                case (step_reg)
                    3'd0:    word = word_lv(opc.lv_op, a,
                                            {{(LIT_BITS-16){1'b0}}, cmd.literal[31:16]});
                    3'd1:    word = word_lv(opc.lv_op, t, LIT_BITS'(32'h1_0000));
                    3'd2:    word = word3(opc.mul_op, a, a, t);
                    3'd3:    word = word_lv(opc.lv_op, t,
                                            {{(LIT_BITS-16){1'b0}}, cmd.literal[15:0]});
                    default: word = word3(opc.add_op, a, a, t);
                endcase
            end
            KIND_MISSING_TEMP: word = '0;
            default:           word = '0;
        endcase
    end

    // step control
    assign advance = !valid_reg || pop;
    assign take    = advance && !cmd_empty;
    assign at_last = (step_reg == len - 3'd1);
    assign cmd_pop = take && at_last;

    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = !cmd_empty;
        end
        if (take)
        begin
            step_next = at_last ? 3'd0 : step_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg <= word;
            last_reg <= at_last;
            err_reg  <= (cmd.kind == KIND_MISSING_TEMP);
        end
    end

    assign empty        = !valid_reg;
    assign instr_word   = word_reg;
    assign last_word    = last_reg;
    assign missing_temp = err_reg;

    // an error result is a lone, zero word
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && err_reg) |-> (last_reg && word_reg == '0))
        else $error("missing-temp result not a single zero word");

    // a request in progress never leaves the queue early
    a_step_held: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != 3'd0) |-> !cmd_empty)
        else $error("sequencer mid-request with empty queue");

    // step stays inside the expansion length
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_empty |-> (step_reg < len))
        else $error("sequencer step beyond expansion length");

endmodule

### hw/rtl/um_macro_instruction_expander.sv
// ----------------------------------------------------------------------------
// um_macro_instruction_expander
// Expands one macro request into one to five machine instruction words.
// ----------------------------------------------------------------------------
// Requests go in through push/full and words come out through empty/pop. A
// request turns into as many result words as its expansion has (one to five,
// one on a missing-temporary error); the sequencer emits one word per cycle
// while the output is popped, and requests follow each other with no gap.
// Up to FIFO_DEPTH classified requests wait between the classifier and the
// sequencer, so push keeps being taken while a word waits to be popped.
// Action 7 is taken and produces no words. The user writes opcode registers
// via wr_en/wr_index/wr_data only while idle; the block does not enforce it.
module um_macro_instruction_expander
    import ume_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  action,
    input  logic        temp_present,
    input  logic [2:0]  temp_reg,
    input  logic [2:0]  reg_a,
    input  logic [2:0]  reg_b,
    input  logic [2:0]  reg_c,
    input  logic [31:0] literal,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] instr_word,
    output logic        last_word,
    output logic        missing_temp,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [3:0]  wr_data
);

    opc_t opc_reg;
    opc_t opc_next;
    cmd_t front_cmd;
    cmd_t head_cmd;
    logic front_push;
    logic q_full;
    logic q_empty;
    logic q_pop;

    // opcode registers
    always_comb
    begin
        opc_next = opc_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_NAND_OPCODE: opc_next.nand_op = wr_data;
                CFG_ADD_OPCODE:  opc_next.add_op  = wr_data;
                CFG_MUL_OPCODE:  opc_next.mul_op  = wr_data;
                CFG_LV_OPCODE:   opc_next.lv_op   = wr_data;
                default:         opc_next = opc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opc_reg.nand_op <= NAND_OPCODE_RST;
            opc_reg.add_op  <= ADD_OPCODE_RST;
            opc_reg.mul_op  <= MUL_OPCODE_RST;
            opc_reg.lv_op   <= LV_OPCODE_RST;
        end
        else
        begin
            opc_reg <= opc_next;
        end
    end

    assign full = q_full;

    // classifier
    ume_front u_front (
        .accept       (push && !q_full),
        .action       (action),
        .temp_present (temp_present),
        .temp_reg     (temp_reg),
        .reg_a        (reg_a),
        .reg_b        (reg_b),
        .reg_c        (reg_c),
        .literal      (literal),
        .cmd_push     (front_push),
        .cmd          (front_cmd)
    );

    // request queue
    ume_cmd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_push),
        .wr_cmd   (front_cmd),
        .rd_taken (q_pop),
        .rd_cmd   (head_cmd),
        .q_full   (q_full),
        .q_empty  (q_empty)
    );

    // sequencer
    ume_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .opc          (opc_reg),
        .cmd          (head_cmd),
        .cmd_empty    (q_empty),
        .cmd_pop      (q_pop),
        .pop          (pop),
        .empty        (empty),
        .instr_word   (instr_word),
        .last_word    (last_word),
        .missing_temp (missing_temp)
    );

endmodule

### verif/um_macro_instruction_expander_test.sv
// ----------------------------------------------------------------------------
// um_macro_instruction_expander_test
// Self-checking bench for the macro instruction expander. A directed table of
// requests runs first at the reset opcodes, then random requests under several
// opcode settings, with handshakes idling at random but in one phase, and one
// long output stall; popped words are compared with typed or expanded words.
// ----------------------------------------------------------------------------
module um_macro_instruction_expander_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ume_pkg::*;

    localparam logic [2:0] ACT_UNDEFINED = 3'd7;
    localparam int NUM_DIRECTED = 20;
    localparam int NUM_PHASES = 5;
    localparam int RANDOM_PER_PHASE = 38;
    localparam int IDLE_PERCENT = 20;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_CYCLES = 120;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [2:0]  action;
        logic        temp_present;
        logic [2:0]  temp_reg;
        logic [2:0]  reg_a;
        logic [2:0]  reg_b;
        logic [2:0]  reg_c;
        logic [31:0] literal;
    } request_t;

    typedef struct packed {
        logic [31:0] instr_word;
        logic        last_word;
        logic        missing_temp;
    } word_t;

    typedef struct packed {
        request_t    req;
        logic        typed;
        logic [31:0] typed_word;
        logic        typed_missing;
    } directed_row_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  action = '0;
    logic        temp_present = 1'b0;
    logic [2:0]  temp_reg = '0;
    logic [2:0]  reg_a = '0;
    logic [2:0]  reg_b = '0;
    logic [2:0]  reg_c = '0;
    logic [31:0] literal = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] instr_word;
    logic        last_word;
    logic        missing_temp;
    logic        wr_en = 1'b0;
    logic [1:0]  wr_index = '0;
    logic [3:0]  wr_data = '0;

    // bench copy of the opcode registers
    opc_t opcodes = '{NAND_OPCODE_RST, ADD_OPCODE_RST, MUL_OPCODE_RST, LV_OPCODE_RST};

    word_t expected_words [$];
    word_t popped_word;
    int    errors = 0;
    logic  no_idle = 1'b0;
    logic  stall_request = 1'b0;
    int    hold_left = 0;
    bit    hold_done = 1'b0;
    int    quiet_cycles = 0;

    um_macro_instruction_expander dut (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // three-register word
    function automatic logic [31:0] reg_word(input logic [3:0] op, input logic [2:0] a,
                                             input logic [2:0] b, input logic [2:0] c);
        return {op, 19'd0, a, b, c};
    endfunction

    // load-value word
    function automatic logic [31:0] value_word(input logic [3:0] op, input logic [2:0] r,
                                               input logic [24:0] v);
        return {op, r, v};
    endfunction

    function automatic bit fits_literal(input logic [31:0] v);
        return (v >> LIT_BITS) == 32'd0;
    endfunction

    // expansion of one request into the words the block must emit
    task automatic expand_request(input request_t r);
        logic [31:0] w [5];
        logic [31:0] inverted;
        int          n;
        bit          need_temp;
        word_t       e;
        n = 0;
        need_temp = 1'b0;
        inverted = ~r.literal;
        case (r.action)
            ACT_COMPLEMENT:
            begin
                w[0] = reg_word(opcodes.nand_op, r.reg_a, r.reg_b, r.reg_b);
                n = 1;
            end
            ACT_MOVE:
            begin
                w[0] = reg_word(opcodes.nand_op, r.reg_a, r.reg_b, r.reg_b);
                w[1] = reg_word(opcodes.nand_op, r.reg_a, r.reg_a, r.reg_a);
                n = 2;
            end
            ACT_NEGATE:
            begin
                need_temp = 1'b1;
                w[0] = reg_word(opcodes.nand_op, r.temp_reg, r.reg_b, r.reg_b);
                w[1] = value_word(opcodes.lv_op, r.reg_a, 25'd1);
                w[2] = reg_word(opcodes.add_op, r.reg_a, r.reg_a, r.temp_reg);
                n = 3;
            end
            ACT_SUBTRACT:
            begin
                need_temp = 1'b1;
                w[0] = reg_word(opcodes.nand_op, r.temp_reg, r.reg_c, r.reg_c);
                w[1] = reg_word(opcodes.add_op, r.reg_a, r.reg_b, r.temp_reg);
                w[2] = value_word(opcodes.lv_op, r.temp_reg, 25'd1);
                w[3] = reg_word(opcodes.add_op, r.reg_a, r.reg_a, r.temp_reg);
                n = 4;
            end
            ACT_AND:
            begin
                w[0] = reg_word(opcodes.nand_op, r.reg_a, r.reg_b, r.reg_c);
                w[1] = reg_word(opcodes.nand_op, r.reg_a, r.reg_a, r.reg_a);
                n = 2;
            end
            ACT_OR:
            begin
                need_temp = 1'b1;
                w[0] = reg_word(opcodes.nand_op, r.temp_reg, r.reg_b, r.reg_b);
                w[1] = reg_word(opcodes.nand_op, r.reg_a, r.reg_c, r.reg_c);
                w[2] = reg_word(opcodes.nand_op, r.reg_a, r.temp_reg, r.reg_a);
                n = 3;
            end
            ACT_LOAD:
            begin
                if (fits_literal(r.literal))
                begin
                    w[0] = value_word(opcodes.lv_op, r.reg_a, r.literal[24:0]);
                    n = 1;
                end
                else if (fits_literal(inverted))
                begin
                    w[0] = value_word(opcodes.lv_op, r.reg_a, inverted[24:0]);
                    w[1] = reg_word(opcodes.nand_op, r.reg_a, r.reg_a, r.reg_a);
                    n = 2;
                end
                else
                begin
                    // wide literal: high half, shift by 65536, add low half
                    need_temp = 1'b1;
                    w[0] = value_word(opcodes.lv_op, r.reg_a, {9'd0, r.literal[31:16]});
                    w[1] = value_word(opcodes.lv_op, r.temp_reg, 25'h001_0000);
                    w[2] = reg_word(opcodes.mul_op, r.reg_a, r.reg_a, r.temp_reg);
                    w[3] = value_word(opcodes.lv_op, r.temp_reg, {9'd0, r.literal[15:0]});
                    w[4] = reg_word(opcodes.add_op, r.reg_a, r.reg_a, r.temp_reg);
                    n = 5;
                end
            end
            default:
            begin
                n = 0;
            end
        endcase
        if (need_temp && !r.temp_present)
        begin
            e.instr_word = 32'd0;
            e.last_word = 1'b1;
            e.missing_temp = 1'b1;
            expected_words.push_back(e);
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                e.instr_word = w[i];
                e.last_word = (i == n - 1);
                e.missing_temp = 1'b0;
                expected_words.push_back(e);
            end
        end
    endtask

    function automatic directed_row_t make_row(input logic [2:0] act, input logic tp,
                                               input logic [2:0] t, input logic [2:0] a,
                                               input logic [2:0] b, input logic [2:0] c,
                                               input logic [31:0] lit, input logic typed,
                                               input logic [31:0] word, input logic miss);
        directed_row_t d;
        d.req = '{act, tp, t, a, b, c, lit};
        d.typed = typed;
        d.typed_word = word;
        d.typed_missing = miss;
        return d;
    endfunction

    // directed table, run at the reset opcodes
    function automatic directed_row_t directed_row(input int i);
        directed_row_t d;
        case (i)
            0:  d = make_row(ACT_COMPLEMENT, 1'b1, 3'd0, 3'd7, 3'd5, 3'd0, 32'h0000_0000,
                             1'b1, 32'h6000_01ED, 1'b0);
            1:  d = make_row(ACT_COMPLEMENT, 1'b0, 3'd7, 3'd0, 3'd0, 3'd7, 32'hFFFF_FFFF,
                             1'b1, 32'h6000_0000, 1'b0);
            2:  d = make_row(ACT_MOVE, 1'b0, 3'd0, 3'd3, 3'd6, 3'd1, 32'h0, 1'b0, 32'h0, 1'b0);
            3:  d = make_row(ACT_NEGATE, 1'b1, 3'd7, 3'd1, 3'd2, 3'd0, 32'h0, 1'b0, 32'h0, 1'b0);
            // negate without a temporary
            4:  d = make_row(ACT_NEGATE, 1'b0, 3'd7, 3'd1, 3'd2, 3'd0, 32'h0,
                             1'b1, 32'h0, 1'b1);
            5:  d = make_row(ACT_SUBTRACT, 1'b1, 3'd5, 3'd7, 3'd7, 3'd7, 32'h0,
                             1'b0, 32'h0, 1'b0);
            6:  d = make_row(ACT_SUBTRACT, 1'b0, 3'd0, 3'd2, 3'd4, 3'd6, 32'h0,
                             1'b1, 32'h0, 1'b1);
            7:  d = make_row(ACT_AND, 1'b0, 3'd0, 3'd2, 3'd3, 3'd4, 32'h0, 1'b0, 32'h0, 1'b0);
            8:  d = make_row(ACT_OR, 1'b1, 3'd6, 3'd5, 3'd1, 3'd0, 32'h0, 1'b0, 32'h0, 1'b0);
            9:  d = make_row(ACT_OR, 1'b0, 3'd6, 3'd5, 3'd1, 3'd0, 32'h0, 1'b1, 32'h0, 1'b1);
            // short literal extremes
            10: d = make_row(ACT_LOAD, 1'b0, 3'd0, 3'd0, 3'd0, 3'd0, 32'h0000_0000,
                             1'b1, 32'hD000_0000, 1'b0);
            11: d = make_row(ACT_LOAD, 1'b0, 3'd0, 3'd7, 3'd0, 3'd0, 32'h01FF_FFFF,
                             1'b1, 32'hDFFF_FFFF, 1'b0);
            // smallest wide literal
            12: d = make_row(ACT_LOAD, 1'b1, 3'd3, 3'd4, 3'd0, 3'd0, 32'h0200_0000,
                             1'b0, 32'h0, 1'b0);
            // complement just fits
            13: d = make_row(ACT_LOAD, 1'b0, 3'd0, 3'd2, 3'd0, 3'd0, 32'hFE00_0000,
                             1'b0, 32'h0, 1'b0);
            14: d = make_row(ACT_LOAD, 1'b0, 3'd0, 3'd6, 3'd0, 3'd0, 32'hFFFF_FFFF,
                             1'b0, 32'h0, 1'b0);
            // wide literal without a temporary
            15: d = make_row(ACT_LOAD, 1'b0, 3'd3, 3'd4, 3'd0, 3'd0, 32'h0200_0000,
                             1'b1, 32'h0, 1'b1);
            16: d = make_row(ACT_LOAD, 1'b1, 3'd1, 3'd0, 3'd0, 3'd0, 32'hFDFF_FFFF,
                             1'b0, 32'h0, 1'b0);
            17: d = make_row(ACT_LOAD, 1'b0, 3'd7, 3'd7, 3'd7, 3'd7, 32'h8000_0000,
                             1'b1, 32'h0, 1'b1);
            // undefined action gives no words
            18: d = make_row(ACT_UNDEFINED, 1'b1, 3'd7, 3'd7, 3'd7, 3'd7, 32'hFFFF_FFFF,
                             1'b0, 32'h0, 1'b0);
            default: d = make_row(ACT_LOAD, 1'b1, 3'd7, 3'd7, 3'd0, 3'd0, 32'hDEAD_BEEF,
                                  1'b0, 32'h0, 1'b0);
        endcase
        return d;
    endfunction

    function automatic request_t random_request();
        request_t r;
        r.action = ($urandom_range(99) < 4) ? ACT_UNDEFINED : 3'($urandom_range(6));
        r.temp_present = ($urandom_range(99) < 80);
        r.temp_reg = 3'($urandom_range(7));
        r.reg_a = 3'($urandom_range(7));
        r.reg_b = 3'($urandom_range(7));
        r.reg_c = 3'($urandom_range(7));
        // spread literals over short, inverted, wide and boundary values
        case ($urandom_range(4))
            0: r.literal = $urandom & 32'h01FF_FFFF;
            1: r.literal = ~($urandom & 32'h01FF_FFFF);
            2, 3: r.literal = $urandom;
            default:
            begin
                case ($urandom_range(5))
                    0: r.literal = 32'h0000_0000;
                    1: r.literal = 32'h01FF_FFFF;
                    2: r.literal = 32'h0200_0000;
                    3: r.literal = 32'hFE00_0000;
                    4: r.literal = 32'hFDFF_FFFF;
                    default: r.literal = 32'hFFFF_FFFF;
                endcase
            end
        endcase
        return r;
    endfunction

    // offer one request and return at the edge that takes it
    task automatic send_request(input request_t r);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        action <= r.action;
        temp_present <= r.temp_present;
        temp_reg <= r.temp_reg;
        reg_a <= r.reg_a;
        reg_b <= r.reg_b;
        reg_c <= r.reg_c;
        literal <= r.literal;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [3:0] data);
        wr_en <= 1'b1;
        wr_index <= index;
        wr_data <= data;
        @(posedge clk);
    endtask

    task automatic set_opcodes(input opc_t v);
        write_register(CFG_NAND_OPCODE, v.nand_op);
        write_register(CFG_ADD_OPCODE, v.add_op);
        write_register(CFG_MUL_OPCODE, v.mul_op);
        write_register(CFG_LV_OPCODE, v.lv_op);
        wr_en <= 1'b0;
        opcodes = v;
    endtask

    // wait out every expected word, then let any wordless request clear
    task automatic wait_drained();
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        request_t      r;
        directed_row_t d;
        word_t         e;
        opc_t          phase_opc;
        int            sent;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            d = directed_row(i);
            send_request(d.req);
            if (d.typed)
            begin
                e.instr_word = d.typed_word;
                e.last_word = 1'b1;
                e.missing_temp = d.typed_missing;
                expected_words.push_back(e);
            end
            else
            begin
                expand_request(d.req);
            end
        end
        push <= 1'b0;
        wait_drained();

        // random phases, one opcode setting each
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: phase_opc = '{4'h0, 4'h0, 4'h0, 4'h0};
                1: phase_opc = '{4'hF, 4'hF, 4'hF, 4'hF};
                2: phase_opc = '{4'hA, 4'h5, 4'hC, 4'h3};
                default: phase_opc = '{4'($urandom_range(15)), 4'($urandom_range(15)),
                                       4'($urandom_range(15)), 4'($urandom_range(15))};
            endcase
            no_idle <= (p == 2);
            if (p == 1)
                stall_request <= 1'b1;
            set_opcodes(phase_opc);
            sent = 0;
            while (sent < RANDOM_PER_PHASE)
            begin
                r = random_request();
                send_request(r);
                expand_request(r);
                if (r.action != ACT_UNDEFINED)
                    sent++;
            end
            push <= 1'b0;
            wait_drained();
        end

        if (errors == 0 && expected_words.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // output side: check each popped word, then decide the next pop
    always @(posedge clk)
    begin
        if (pop && !empty)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected word: instr_word %h last_word %b missing_temp %b",
                       instr_word, last_word, missing_temp);
                errors++;
            end
            else
            begin
                popped_word = expected_words.pop_front();
                if (instr_word !== popped_word.instr_word)
                begin
                    $error("instr_word mismatch: expected %h, actual %h",
                           popped_word.instr_word, instr_word);
                    errors++;
                end
                if (last_word !== popped_word.last_word)
                begin
                    $error("last_word mismatch: expected %b, actual %b",
                           popped_word.last_word, last_word);
                    errors++;
                end
                if (missing_temp !== popped_word.missing_temp)
                begin
                    $error("missing_temp mismatch: expected %b, actual %b",
                           popped_word.missing_temp, missing_temp);
                    errors++;
                end
            end
        end

        // one long hold-off lets the block fill and push back on its input
        if (!rst_n)
            pop <= 1'b0;
        else if (stall_request && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = STALL_CYCLES;
            pop <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else if (no_idle)
            pop <= 1'b1;
        else
            pop <= ($urandom_range(99) >= IDLE_PERCENT);
    end

    // watchdog on cycles with no request taken and no word popped
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
